>>> src/vwir_pkg.sv
`default_nettype none

package vwir_pkg;

  // table sizes
  localparam int unsigned MAX_POINTS = 1024;
  localparam int unsigned IDX_W      = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W      = $clog2(MAX_POINTS + 1);

  // coordinate arithmetic
  localparam int unsigned COORD_BITS = 24;
  localparam int unsigned PT_W       = 3 * COORD_BITS;
  localparam int unsigned DIFF_W     = COORD_BITS + 1;
  localparam int unsigned SQ_W       = 2 * DIFF_W;
  localparam int unsigned ACC_W      = SQ_W + 2;
  localparam int unsigned TOL_W      = 52;
  localparam int unsigned CMP_W      = (ACC_W > TOL_W) ? ACC_W : TOL_W;

  // fixed field widths
  localparam int unsigned FIELD_W = 24;
  localparam int unsigned FIDX_W  = 32;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMAP  = 2'd1,
    REQ_CLEAR  = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_SQ,
    ST_CMP,
    ST_APPEND,
    ST_REMAP,
    ST_RESP
  } state_e;

  // squaring phase: one coordinate per step, last step only accumulates
  typedef enum logic [1:0] {
    PH_X   = 2'd0,
    PH_Y   = 2'd1,
    PH_Z   = 2'd2,
    PH_ACC = 2'd3
  } phase_e;

endpackage

`default_nettype wire

>>> src/vertex_weld_index_remap_core.sv
// Channel  | Direction | Handshake                 | Payload
// ---------+-----------+---------------------------+---------------------------------------
// in       | input     | in_valid_i / in_stall_o   | req_type, x/y/z_coord, face_index
// out      | output    | out_valid_o / out_stall_i | result_index, is_new, overflow
// cfg      | input     | cfg_we_i                  | cfg_wdata_i (tol_sq)
//
// Insert: each stored point is scanned in steps (read, 3 squares on the one shared squarer,
// final add, compare); a hit on point m ends the scan there, a miss over all u stored points
// appends the point. In-range remap reads the map first; all else answers directly.
// One item is in work at a time; the output register lets the next beat in while a
// result still waits. Reset empties both tables and sets tol_sq to 0.
`default_nettype none

module vertex_weld_index_remap_core
  import vwir_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,

  input  wire logic                     cfg_we_i,
  input  wire logic [TOL_W-1:0]         cfg_wdata_i,

  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [1:0]               req_type_i,
  input  wire logic signed [FIELD_W-1:0] x_coord_i,
  input  wire logic signed [FIELD_W-1:0] y_coord_i,
  input  wire logic signed [FIELD_W-1:0] z_coord_i,
  input  wire logic signed [FIDX_W-1:0] face_index_i,

  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic signed [FIDX_W-1:0]      result_index_o,
  output logic                          is_new_o,
  output logic                          overflow_o
);

  // control state
  state_e             state_q, state_d;
  phase_e             phase_q, phase_d;
  logic [CNT_W-1:0]   ucnt_q, ucnt_d;
  logic [CNT_W-1:0]   ocnt_q, ocnt_d;
  logic [IDX_W-1:0]   j_q, j_d;
  logic [TOL_W-1:0]   tol_q;
  logic               out_valid_q, out_valid_d;

  // payload state
  logic signed [COORD_BITS-1:0] px_q, py_q, pz_q, px_d, py_d, pz_d;
  logic [SQ_W-1:0]    sq_q, sq_d;
  logic [ACC_W-1:0]   acc_q, acc_d;
  logic               neg_q, neg_d;
  logic [FIDX_W-1:0]  res_idx_q, res_idx_d;
  logic               res_new_q, res_new_d;
  logic               res_ovf_q, res_ovf_d;
  logic [FIDX_W-1:0]  out_idx_q;
  logic               out_new_q, out_ovf_q;

  // memories
  logic [PT_W-1:0]    pt_mem [MAX_POINTS];
  logic [CNT_W-1:0]   map_mem [MAX_POINTS];
  logic [PT_W-1:0]    pt_rd_q;
  logic [CNT_W-1:0]   map_rd_q;
  logic               pt_we, pt_rd_en, map_we, map_rd_en;
  logic [IDX_W-1:0]   pt_waddr, map_waddr, map_raddr;
  logic [CNT_W-1:0]   map_wdata;

  // condition signals
  logic               in_acc, out_free, map_full, uniq_full, hit, last_pt;
  logic               fi_neg, in_range;
  logic [FIDX_W:0]    fi_ext, fi_mag;
  logic [CNT_W-1:0]   j_next;

  // shared squarer operands
  logic signed [COORD_BITS-1:0] sel_a, sel_b;
  logic signed [DIFF_W-1:0]     diff;
  logic [DIFF_W-1:0]            mag;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign map_full   = (ocnt_q == CNT_W'(MAX_POINTS));
  assign uniq_full  = (ucnt_q == CNT_W'(MAX_POINTS));
  // sum stays exact, so the compare is unaffected
  assign hit        = (CMP_W'(acc_q) < CMP_W'(tol_q));
  assign j_next     = CNT_W'(j_q) + CNT_W'(1);
  assign last_pt    = (j_next == ucnt_q);

  // remap range check on the signed 1-based index
  assign fi_neg   = face_index_i[FIDX_W-1];
  assign fi_ext   = {face_index_i[FIDX_W-1], face_index_i};
  assign fi_mag   = fi_neg ? ((FIDX_W+1)'(0) - fi_ext) : fi_ext;
  assign in_range = (fi_mag != '0) && (fi_mag <= (FIDX_W+1)'(ocnt_q));

  // coordinate select for the current phase
  always_comb begin
    case (phase_q)
      PH_X: begin
        sel_a = px_q;
        sel_b = pt_rd_q[PT_W-1 -: COORD_BITS];
      end
      PH_Y: begin
        sel_a = py_q;
        sel_b = pt_rd_q[2*COORD_BITS-1 -: COORD_BITS];
      end
      default: begin
        sel_a = pz_q;
        sel_b = pt_rd_q[COORD_BITS-1:0];
      end
    endcase
  end

  assign diff = DIFF_W'(sel_a) - DIFF_W'(sel_b);
  assign mag  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (req_type_i)
            REQ_INSERT: begin
              if (map_full)             state_d = ST_RESP;
              else if (ucnt_q == '0)    state_d = ST_APPEND;
              else                      state_d = ST_RD;
            end
            REQ_REMAP: state_d = in_range ? ST_REMAP : ST_RESP;
            default:   state_d = ST_RESP;
          endcase
        end
      end
      ST_RD:     state_d = ST_SQ;
      ST_SQ:     state_d = (phase_q == PH_ACC) ? ST_CMP : ST_SQ;
      ST_CMP: begin
        if (hit)          state_d = ST_RESP;
        else if (last_pt) state_d = ST_APPEND;
        else              state_d = ST_RD;
      end
      ST_APPEND: state_d = ST_RESP;
      ST_REMAP:  state_d = ST_RESP;
      ST_RESP:   state_d = out_free ? ST_IDLE : ST_RESP;
      default:   state_d = ST_IDLE;
    endcase
  end

  // datapath and table controls
  always_comb begin
    phase_d     = phase_q;
    ucnt_d      = ucnt_q;
    ocnt_d      = ocnt_q;
    j_d         = j_q;
    px_d        = px_q;
    py_d        = py_q;
    pz_d        = pz_q;
    sq_d        = sq_q;
    acc_d       = acc_q;
    neg_d       = neg_q;
    res_idx_d   = res_idx_q;
    res_new_d   = res_new_q;
    res_ovf_d   = res_ovf_q;
    pt_we       = 1'b0;
    pt_rd_en    = 1'b0;
    map_we      = 1'b0;
    map_rd_en   = 1'b0;
    pt_waddr    = ucnt_q[IDX_W-1:0];
    map_waddr   = ocnt_q[IDX_W-1:0];
    map_wdata   = j_next;
    map_raddr   = IDX_W'(fi_mag - (FIDX_W+1)'(1));
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          px_d      = x_coord_i[COORD_BITS-1:0];
          py_d      = y_coord_i[COORD_BITS-1:0];
          pz_d      = z_coord_i[COORD_BITS-1:0];
          j_d       = '0;
          neg_d     = fi_neg;
          res_idx_d = '0;
          res_new_d = 1'b0;
          res_ovf_d = 1'b0;
          case (req_type_i)
            REQ_INSERT: res_ovf_d = map_full;
            REQ_REMAP: begin
              if (in_range) map_rd_en = 1'b1;
              else          res_idx_d = face_index_i;
            end
            REQ_CLEAR: begin
              ucnt_d = '0;
              ocnt_d = '0;
            end
            default: ;
          endcase
        end
      end
      ST_RD: begin
        pt_rd_en = 1'b1;
        phase_d  = PH_X;
      end
      ST_SQ: begin
        sq_d = SQ_W'(mag) * SQ_W'(mag);
        if (phase_q == PH_X) acc_d = '0;
        else                 acc_d = acc_q + ACC_W'(sq_q);
        phase_d = phase_e'(phase_q + 2'd1);
      end
      ST_CMP: begin
        if (hit) begin
          map_we    = 1'b1;
          ocnt_d    = ocnt_q + CNT_W'(1);
          res_idx_d = FIDX_W'(j_next);
        end else if (!last_pt) begin
          j_d = j_q + IDX_W'(1);
        end
      end
      ST_APPEND: begin
        if (uniq_full) begin
          res_idx_d = '0;
          res_ovf_d = 1'b1;
        end else begin
          pt_we     = 1'b1;
          map_we    = 1'b1;
          map_wdata = ucnt_q + CNT_W'(1);
          ucnt_d    = ucnt_q + CNT_W'(1);
          ocnt_d    = ocnt_q + CNT_W'(1);
          res_idx_d = FIDX_W'(ucnt_q + CNT_W'(1));
          res_new_d = 1'b1;
        end
      end
      ST_REMAP: begin
        res_idx_d = neg_q ? (FIDX_W'(0) - FIDX_W'(map_rd_q)) : FIDX_W'(map_rd_q);
      end
      ST_RESP: begin
        if (out_free) out_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_X;
      ucnt_q      <= '0;
      ocnt_q      <= '0;
      j_q         <= '0;
      tol_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      ucnt_q      <= ucnt_d;
      ocnt_q      <= ocnt_d;
      j_q         <= j_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) tol_q <= cfg_wdata_i;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    px_q      <= px_d;
    py_q      <= py_d;
    pz_q      <= pz_d;
    sq_q      <= sq_d;
    acc_q     <= acc_d;
    neg_q     <= neg_d;
    res_idx_q <= res_idx_d;
    res_new_q <= res_new_d;
    res_ovf_q <= res_ovf_d;
    if (state_q == ST_RESP && out_free) begin
      out_idx_q <= res_idx_q;
      out_new_q <= res_new_q;
      out_ovf_q <= res_ovf_q;
    end
  end

  // unique point table
  always_ff @(posedge clk_i) begin
    if (pt_we)    pt_mem[pt_waddr] <= {px_q, py_q, pz_q};
    if (pt_rd_en) pt_rd_q <= pt_mem[j_q];
  end

  // original-to-unique map
  always_ff @(posedge clk_i) begin
    if (map_we)    map_mem[map_waddr] <= map_wdata;
    if (map_rd_en) map_rd_q <= map_mem[map_raddr];
  end

  assign out_valid_o    = out_valid_q;
  assign result_index_o = out_idx_q;
  assign is_new_o       = out_new_q;
  assign overflow_o     = out_ovf_q;

endmodule

`default_nettype wire

>>> src/vwir_checker.sv
`default_nettype none

module vwir_checker
  import vwir_pkg::*;
(
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      in_valid_i,
  input wire logic                      in_stall_o,
  input wire logic                      out_valid_o,
  input wire logic                      out_stall_i,
  input wire logic signed [FIDX_W-1:0]  result_index_o,
  input wire logic                      is_new_o,
  input wire logic                      overflow_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_index_o)
      && $stable(is_new_o) && $stable(overflow_o))
    else $error("stalled result beat changed");

  // one item at a time: the block is busy right after a beat is taken
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken back to back");

  // overflow answers carry index zero and no new flag
  a_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |-> (result_index_o == '0) && !is_new_o)
    else $error("overflow beat with index or new flag");

  // a new point gets a positive index
  a_new: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_new_o |-> (result_index_o > 0) && !overflow_o)
    else $error("new point without positive index");

endmodule

bind vertex_weld_index_remap_core vwir_checker u_vwir_checker (.*);

`default_nettype wire

>>> tb/sv/testbench.sv
module testbench;
  import vwir_pkg::*;

  localparam logic [1:0]         REQ_UNUSED  = 2'd3;
  localparam logic [TOL_W-1:0]   TOL_MAX     = '1;
  localparam logic [FIELD_W-1:0] COORD_MAX   = {1'b0, {(FIELD_W-1){1'b1}}};
  localparam logic [FIELD_W-1:0] COORD_MIN   = {1'b1, {(FIELD_W-1){1'b0}}};
  localparam int unsigned        UNIQ_CAP    = 48;    // clear before scans get long
  localparam int unsigned        PHASE_BEATS = 80;
  localparam int unsigned        HOLD_AT     = 200;   // result count that starts the long hold
  localparam int unsigned        HOLD_CYCLES = 400;
  localparam int unsigned        IDLE_LIMIT  = 10000;

  typedef struct packed {
    logic [1:0]                req;
    logic signed [FIELD_W-1:0] x;
    logic signed [FIELD_W-1:0] y;
    logic signed [FIELD_W-1:0] z;
    logic signed [FIDX_W-1:0]  face;
  } weld_req_t;

  typedef struct packed {
    logic signed [FIDX_W-1:0] index;
    logic                     is_new;
    logic                     ovf;
  } weld_ans_t;

  // Shadow of the weld tables plus the queue of answers still owed by the block
  class weld_scoreboard;
    logic [TOL_W-1:0]          tol_sq;
    logic signed [FIELD_W-1:0] pt_x [MAX_POINTS];
    logic signed [FIELD_W-1:0] pt_y [MAX_POINTS];
    logic signed [FIELD_W-1:0] pt_z [MAX_POINTS];
    int unsigned               weld_map [MAX_POINTS];
    int unsigned               uniq_cnt;
    int unsigned               orig_cnt;
    weld_ans_t                 answer_q [$];
    int unsigned               errors;

    function new();
      tol_sq   = '0;
      uniq_cnt = 0;
      orig_cnt = 0;
      errors   = 0;
    endfunction

    // first stored point, in insertion order, strictly inside the tolerance; 0 if none
    function int unsigned find_match(weld_req_t beat);
      longint          dx, dy, dz;
      longint unsigned sum_sq;
      for (int unsigned j = 0; j < uniq_cnt; j++) begin
        dx     = $signed(beat.x) - $signed(pt_x[j]);
        dy     = $signed(beat.y) - $signed(pt_y[j]);
        dz     = $signed(beat.z) - $signed(pt_z[j]);
        sum_sq = dx * dx + dy * dy + dz * dz;
        if (sum_sq < 64'(tol_sq)) return j + 1;
      end
      return 0;
    endfunction

    // accepted input beat: update the tables and queue the answer it owes
    function void note_beat(weld_req_t beat);
      weld_ans_t   ans;
      int unsigned hit;
      longint      idx;
      ans = '0;
      case (beat.req)
        REQ_INSERT: begin
          if (orig_cnt >= MAX_POINTS) begin
            ans.ovf = 1'b1;
          end else begin
            hit = find_match(beat);
            if (hit != 0) begin
              weld_map[orig_cnt] = hit;
              orig_cnt++;
              ans.index = hit;
            end else if (uniq_cnt >= MAX_POINTS) begin
              ans.ovf = 1'b1;
            end else begin
              pt_x[uniq_cnt] = beat.x;
              pt_y[uniq_cnt] = beat.y;
              pt_z[uniq_cnt] = beat.z;
              uniq_cnt++;
              weld_map[orig_cnt] = uniq_cnt;
              orig_cnt++;
              ans.index  = uniq_cnt;
              ans.is_new = 1'b1;
            end
          end
        end
        REQ_REMAP: begin
          idx = $signed(beat.face);
          if (idx > 0 && idx <= longint'(orig_cnt)) begin
            ans.index = weld_map[idx - 1];
          end else if (idx < 0 && -idx <= longint'(orig_cnt)) begin
            ans.index = -int'(weld_map[-idx - 1]);
          end else begin
            ans.index = beat.face;
          end
        end
        REQ_CLEAR: begin
          uniq_cnt = 0;
          orig_cnt = 0;
        end
        default: begin
          // unused request: no state change, zero answer
        end
      endcase
      answer_q = {answer_q, ans};
    endfunction

    // accepted result beat: compare with the oldest owed answer
    function void check_beat(weld_ans_t got);
      weld_ans_t want;
      if (answer_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: result with nothing owed: index %0d new %0b ovf %0b",
                   $realtime, got.index, got.is_new, got.ovf);
        return;
      end
      want = answer_q.pop_front();
      if (got.index !== want.index || got.is_new !== want.is_new || got.ovf !== want.ovf) begin
        errors++;
        if (errors <= 10)
          $display("%0t: mismatch: index exp %0d got %0d, new exp %0b got %0b, ovf exp %0b got %0b",
                   $realtime, want.index, got.index, want.is_new, got.is_new,
                   want.ovf, got.ovf);
      end
    endfunction
  endclass

  logic                     clk_i;
  logic                     rst_n     = 1'b0;
  logic                     cfg_we    = 1'b0;
  logic [TOL_W-1:0]         cfg_wdata = '0;
  logic                     in_valid  = 1'b0;
  logic                     in_stall;
  weld_req_t                in_beat   = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [FIDX_W-1:0] result_index;
  logic                     is_new;
  logic                     overflow;
  logic                     calm      = 1'b0;  // no idling on either side
  bit                       sender_idles;
  int unsigned              results_seen = 0;
  int unsigned              quiet_cycles = 0;
  weld_scoreboard           board = new();

  vertex_weld_index_remap_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .req_type_i     (in_beat.req),
    .x_coord_i      (in_beat.x),
    .y_coord_i      (in_beat.y),
    .z_coord_i      (in_beat.z),
    .face_index_i   (in_beat.face),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .result_index_o (result_index),
    .is_new_o       (is_new),
    .overflow_o     (overflow)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // beat builders; fields the request ignores carry noise
  function automatic weld_req_t mk_insert(logic [FIELD_W-1:0] x, logic [FIELD_W-1:0] y,
                                          logic [FIELD_W-1:0] z);
    weld_req_t b;
    b.req  = REQ_INSERT;
    b.x    = x;
    b.y    = y;
    b.z    = z;
    b.face = $urandom;
    return b;
  endfunction

  function automatic weld_req_t mk_remap(logic [FIDX_W-1:0] f);
    weld_req_t b;
    b.req  = REQ_REMAP;
    b.x    = FIELD_W'($urandom);
    b.y    = FIELD_W'($urandom);
    b.z    = FIELD_W'($urandom);
    b.face = f;
    return b;
  endfunction

  function automatic weld_req_t mk_op(logic [1:0] req);
    weld_req_t b;
    b.req  = req;
    b.x    = FIELD_W'($urandom);
    b.y    = FIELD_W'($urandom);
    b.z    = FIELD_W'($urandom);
    b.face = $urandom;
    return b;
  endfunction

  function automatic logic [FIELD_W-1:0] extreme_coord();
    case ($urandom_range(0, 2))
      0: return COORD_MAX;
      1: return COORD_MIN;
      default: return '0;
    endcase
  endfunction

  function automatic logic [FIELD_W-1:0] jitter();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return FIELD_W'(int'($urandom_range(0, 2)) - 1);
      2: return FIELD_W'(int'($urandom_range(0, 32)) - 16);
      default: return FIELD_W'(int'($urandom_range(0, 2048)) - 1024);
    endcase
  endfunction

  // mostly inserts near stored points and in-range remaps, some noise
  function automatic weld_req_t random_beat();
    weld_req_t   b;
    int unsigned pick, j, k;
    b    = mk_op(REQ_INSERT);
    pick = $urandom_range(0, 99);
    if (board.uniq_cnt >= UNIQ_CAP || pick < 5) begin
      b.req = REQ_CLEAR;
    end else if (pick < 9) begin
      b.req = REQ_UNUSED;
    end else if (pick < 40) begin
      b.req = REQ_REMAP;
      if ($urandom_range(0, 3) != 0) begin
        k      = $urandom_range(0, board.orig_cnt + 2);
        b.face = $urandom_range(0, 1) ? -int'(k) : int'(k);
      end
    end else if (board.uniq_cnt != 0 && $urandom_range(0, 9) < 6) begin
      j   = $urandom_range(0, board.uniq_cnt - 1);
      b.x = board.pt_x[j] + jitter();
      b.y = board.pt_y[j] + jitter();
      b.z = board.pt_z[j] + jitter();
    end else if ($urandom_range(0, 7) == 0) begin
      b.x = extreme_coord();
      b.y = extreme_coord();
      b.z = extreme_coord();
    end
    return b;
  endfunction

  // present one beat and hold it until the block takes it
  task automatic send_beat(weld_req_t beat);
    in_beat  <= beat;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (in_stall);
    board.note_beat(beat);
  endtask

  task automatic sender_gap(int unsigned cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic offer(weld_req_t beat);
    if (!calm && sender_idles && $urandom_range(0, 3) == 0)
      sender_gap($urandom_range(1, 16));
    send_beat(beat);
  endtask

  // stop sending and wait for every owed answer
  task automatic drain();
    in_valid <= 1'b0;
    while (board.answer_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_tolerance(logic [TOL_W-1:0] tol);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= tol;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    board.tol_sq = tol;
  endtask

  initial begin : stimulus
    logic [TOL_W-1:0] tol_plan [7];
    tol_plan[0] = '0;
    tol_plan[1] = TOL_W'(1);
    tol_plan[2] = TOL_W'(300);
    tol_plan[3] = TOL_W'(262144);
    tol_plan[4] = TOL_W'({$urandom, $urandom});
    tol_plan[5] = TOL_MAX;
    tol_plan[6] = TOL_W'($urandom_range(0, 1 << 22));
    sender_idles = 1'b1;

    repeat (3) @(posedge clk_i);
    rst_n <= 1'b1;

    // empty tables, reset tolerance: every remap passes through
    offer(mk_remap(0));
    offer(mk_remap(1));
    offer(mk_remap(32'h7FFF_FFFF));
    offer(mk_remap(32'h8000_0000));
    // zero tolerance: even an identical point is appended
    offer(mk_insert('0, '0, '0));
    offer(mk_insert(COORD_MAX, COORD_MAX, COORD_MAX));
    offer(mk_insert(COORD_MIN, COORD_MIN, COORD_MIN));
    offer(mk_insert('0, '0, '0));
    offer(mk_remap(4));
    offer(mk_remap(-2));
    offer(mk_remap(5));
    offer(mk_remap(-5));
    offer(mk_op(REQ_UNUSED));
    offer(mk_op(REQ_CLEAR));
    offer(mk_remap(1));

    // widest tolerance: opposite corners still weld
    set_tolerance(TOL_MAX);
    offer(mk_insert(COORD_MAX, COORD_MAX, COORD_MAX));
    offer(mk_insert(COORD_MIN, COORD_MIN, COORD_MIN));
    offer(mk_remap(-2));

    // tolerance one: only an exact copy welds, distance one does not
    set_tolerance(TOL_W'(1));
    offer(mk_op(REQ_CLEAR));
    offer(mk_insert(FIELD_W'(5), FIELD_W'(5), FIELD_W'(5)));
    offer(mk_insert(FIELD_W'(5), FIELD_W'(5), FIELD_W'(5)));
    offer(mk_insert(FIELD_W'(6), FIELD_W'(5), FIELD_W'(5)));
    offer(mk_insert(FIELD_W'(6), FIELD_W'(5), FIELD_W'(5)));

    // random phases, one tolerance each; the last one runs without idling
    for (int p = 0; p < 7; p++) begin
      set_tolerance(tol_plan[p]);
      sender_idles = (p % 3) != 2;
      if (p == 6) calm <= 1'b1;
      repeat (PHASE_BEATS) offer(random_beat());
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (board.errors == 0 && board.answer_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // result side: random stall bursts, one long hold, quiet stretches
  initial begin : result_sink
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!calm) begin
        if (!held && results_seen >= HOLD_AT) begin
          held = 1'b1;
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk_i);
          out_stall <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(1, 16)) @(posedge clk_i);
          out_stall <= 1'b0;
        end else if ($urandom_range(0, 15) == 0) begin
          repeat ($urandom_range(20, 80)) @(posedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin : result_monitor
    weld_ans_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.index  = result_index;
      got.is_new = is_new;
      got.ovf    = overflow;
      board.check_beat(got);
      results_seen <= results_seen + 1;
    end
  end

  // watchdog: too long without a beat on either channel
  always @(posedge clk_i) begin : watchdog
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
